[hw/rtl/eiec_pkg.sv]
// Package with the shared types and constants of the external interrupt edge controller.
`default_nettype none

package eiec_pkg;

    // Fixed field widths.
    localparam int unsigned NUM_LINES    = 16;
    localparam int unsigned LEVELS_W     = 64;
    localparam int unsigned SEL_W        = 4;
    localparam int unsigned OP_W         = 2;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned CFG_DATA_W   = 64;
    localparam int unsigned GROUP_W      = 3;
    localparam int unsigned FIRST_W      = 5;

    // Item operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_STATUS = 2'd2
    } t_op;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_RISING_ENABLE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FALLING_ENABLE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERRUPT_MASK = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EVENT_MASK     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_SELECT  = 3'd4;

    // Lines that feed each grouped interrupt.
    localparam logic [NUM_LINES-1:0] GROUP0_MASK = 16'h0003;
    localparam logic [NUM_LINES-1:0] GROUP1_MASK = 16'h000C;
    localparam logic [NUM_LINES-1:0] GROUP2_MASK = 16'hFFF0;

    // First-line code when nothing is pending and unmasked.
    localparam logic [FIRST_W-1:0] FIRST_NONE = 5'd16;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [NUM_LINES-1:0]  rising_enable;
        logic [NUM_LINES-1:0]  falling_enable;
        logic [NUM_LINES-1:0]  interrupt_mask;
        logic [NUM_LINES-1:0]  event_mask;
        logic [LEVELS_W-1:0]   source_select;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [NUM_LINES-1:0] pending_lines;
        logic [GROUP_W-1:0]   group_irqs;
        logic [NUM_LINES-1:0] event_pulses;
        logic [FIRST_W-1:0]   first_line;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/eiec_if.sv]
// Handshake interfaces for the input, result and configuration channels.
`default_nettype none

interface eiec_in_if import eiec_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [LEVELS_W-1:0]  port_levels;
    logic [NUM_LINES-1:0] clear_bits;

    modport source (output valid, output op, output port_levels, output clear_bits,
                    input ready);
    modport sink   (input valid, input op, input port_levels, input clear_bits,
                    output ready);
endinterface

interface eiec_out_if import eiec_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [NUM_LINES-1:0] pending_lines;
    logic [GROUP_W-1:0]   group_irqs;
    logic [NUM_LINES-1:0] event_pulses;
    logic [FIRST_W-1:0]   first_line;

    modport source (output valid, output pending_lines, output group_irqs,
                    output event_pulses, output first_line, input ready);
    modport sink   (input valid, input pending_lines, input group_irqs,
                    input event_pulses, input first_line, output ready);
endinterface

interface eiec_cfg_if import eiec_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/eiec_cfg.sv]
// Configuration register file of the external interrupt edge controller.
`default_nettype none

module eiec_cfg
    import eiec_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    eiec_cfg_if.sink           i_cfg,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // The register file takes every write at once.
    assign i_cfg.ready = 1'b1;

    // Decode the register index of a write transaction; unknown indexes are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_RISING_ENABLE:  n_cfg.rising_enable  = i_cfg.data[NUM_LINES-1:0];
                REG_FALLING_ENABLE: n_cfg.falling_enable = i_cfg.data[NUM_LINES-1:0];
                REG_INTERRUPT_MASK: n_cfg.interrupt_mask = i_cfg.data[NUM_LINES-1:0];
                REG_EVENT_MASK:     n_cfg.event_mask     = i_cfg.data[NUM_LINES-1:0];
                REG_SOURCE_SELECT:  n_cfg.source_select  = i_cfg.data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hw/rtl/eiec_core.sv]
// Edge detection, pending state and status logic of the external interrupt edge controller.
`default_nettype none

module eiec_core
    import eiec_pkg::*;
#(
    parameter int unsigned LINE_COUNT = 16,
    parameter int unsigned PORT_COUNT = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [LEVELS_W-1:0]  i_port_levels,
    input  wire logic [NUM_LINES-1:0] i_clear_bits,
    input  wire t_cfg                 i_cfg,
    output t_result                   o_result
);

    logic [NUM_LINES-1:0] r_prev_levels;
    logic [NUM_LINES-1:0] r_pending;
    logic [NUM_LINES-1:0] n_prev_levels;
    logic [NUM_LINES-1:0] n_pending;

    logic [NUM_LINES-1:0] line_mask;
    logic [NUM_LINES-1:0] levels;
    logic [NUM_LINES-1:0] fired;
    logic [NUM_LINES-1:0] events;
    logic [NUM_LINES-1:0] active;
    logic [FIRST_W-1:0]   first;

    // Route each line to the pin of its selected port; ports beyond the count read low.
    always_comb begin
        logic [SEL_W-1:0] sel;
        levels    = '0;
        line_mask = '0;
        for (int l = 0; l < NUM_LINES; l++) begin
            sel = i_cfg.source_select[SEL_W*l +: SEL_W];
            if (l < LINE_COUNT) begin
                line_mask[l] = 1'b1;
                if (sel < SEL_W'(PORT_COUNT)) begin
                    levels[l] = i_port_levels[{sel[1:0], 4'(l)}];
                end
            end
        end
    end

    // Enabled rising or falling edges against the stored levels.
    assign fired = ((levels & ~r_prev_levels & i_cfg.rising_enable) |
                    (~levels & r_prev_levels & i_cfg.falling_enable)) & line_mask;

    // Next state of the levels and pending bits for the current item.
    always_comb begin
        n_prev_levels = r_prev_levels;
        n_pending     = r_pending;
        events        = '0;
        case (i_op)
            OP_SAMPLE: begin
                n_prev_levels = levels;
                n_pending     = (r_pending | fired) & line_mask;
                events        = fired & i_cfg.event_mask;
            end
            OP_CLEAR: begin
                n_pending = r_pending & ~i_clear_bits & line_mask;
            end
            default: begin
                n_pending = r_pending;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_levels <= '0;
            r_pending     <= '0;
        end else if (i_fire) begin
            r_prev_levels <= n_prev_levels;
            r_pending     <= n_pending;
        end
    end

    // Lowest pending unmasked line, scanned from the top so the lowest wins.
    assign active = n_pending & i_cfg.interrupt_mask & line_mask;

    always_comb begin
        first = FIRST_NONE;
        for (int l = NUM_LINES - 1; l >= 0; l--) begin
            if (active[l]) begin
                first = FIRST_W'(l);
            end
        end
    end

    // Result of the current item.
    always_comb begin
        o_result.pending_lines = n_pending;
        o_result.group_irqs    = {|(active & GROUP2_MASK),
                                  |(active & GROUP1_MASK),
                                  |(active & GROUP0_MASK)};
        o_result.event_pulses  = events;
        o_result.first_line    = first;
    end

endmodule

`default_nettype wire

[hw/rtl/external_interrupt_edge_controller_top.sv]
// An accepted input transaction passes the input register and then the result register,
// which part the two channels. Throughput: one transaction per cycle unless the output
// stalls; the pending and level state updates as an item moves between the two registers.
// Reset (synchronous, active low) clears all configuration registers, the stored levels,
// the pending bits and both valid flags.
`default_nettype none

module external_interrupt_edge_controller_top
    import eiec_pkg::*;
#(
    parameter int unsigned LINE_COUNT = 16,
    parameter int unsigned PORT_COUNT = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    eiec_cfg_if.sink    i_cfg,
    eiec_in_if.sink     i_in,
    eiec_out_if.source  o_out
);

    t_cfg    cfg;
    t_result result;

    logic                 r_in_valid;
    logic [OP_W-1:0]      r_op;
    logic [LEVELS_W-1:0]  r_port_levels;
    logic [NUM_LINES-1:0] r_clear_bits;
    logic                 r_out_valid;
    t_result              r_result;
    logic                 advance;

    eiec_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // The held item moves on when the result register is free or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_op          <= i_in.op;
            r_port_levels <= i_in.port_levels;
            r_clear_bits  <= i_in.clear_bits;
        end
    end

    eiec_core #(
        .LINE_COUNT (LINE_COUNT),
        .PORT_COUNT (PORT_COUNT)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (advance),
        .i_op          (r_op),
        .i_port_levels (r_port_levels),
        .i_clear_bits  (r_clear_bits),
        .i_cfg         (cfg),
        .o_result      (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.pending_lines = r_result.pending_lines;
    assign o_out.group_irqs    = r_result.group_irqs;
    assign o_out.event_pulses  = r_result.event_pulses;
    assign o_out.first_line    = r_result.first_line;

endmodule

`default_nettype wire
